>>> sv/duplicate_record_filter_top_macros.svh
// Assertion macros for the duplicate record filter.
`ifndef DUPLICATE_RECORD_FILTER_TOP_MACROS_SVH
`define DUPLICATE_RECORD_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("duplicate_record_filter: assertion failed");
`define DRF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("duplicate_record_filter: assertion failed");
`else
`define DRF_ASSERT(lbl, prop)
`define DRF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> sv/drf_pkg.sv
package drf_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned WordW      = 32;
  localparam int unsigned NodeW      = 16;
  localparam int unsigned UniqueW    = 11;
  localparam int unsigned RecW       = 3 * WordW + 2 * NodeW;
  localparam int unsigned ProdW      = WordW + 7;
  localparam logic [6:0]  PctScale   = 7'd100;

  typedef logic [RecW-1:0] rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FLAG
  } state_e;

endpackage

>>> sv/drf_in_if.sv
interface drf_in_if;
  import drf_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] observer_word;
  logic [WordW-1:0] observed_word;
  logic [WordW-1:0] stamp;
  logic [NodeW-1:0] source_node;
  logic [NodeW-1:0] dest_node;

  modport source (
    output valid, observer_word, observed_word, stamp, source_node, dest_node,
    input  ready
  );
  modport sink (
    input  valid, observer_word, observed_word, stamp, source_node, dest_node,
    output ready
  );
endinterface

>>> sv/drf_out_if.sv
interface drf_out_if;
  import drf_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_new;
  logic               was_stored;
  logic [WordW-1:0]   dup_count;
  logic [WordW-1:0]   acc_count;
  logic [UniqueW-1:0] unique_count;
  logic               protected_flag;

  modport source (
    output valid, is_new, was_stored, dup_count, acc_count, unique_count,
           protected_flag,
    input  ready
  );
  modport sink (
    input  valid, is_new, was_stored, dup_count, acc_count, unique_count,
           protected_flag,
    output ready
  );
endinterface

>>> sv/duplicate_record_filter_top.sv
// Channel  Dir  Beat contents
// in_i     in   observer_word, observed_word, stamp, source_node, dest_node
// out_o    out  is_new, was_stored, dup_count, acc_count, unique_count, protected_flag
//
// ST_SCAN compares the record with each stored record up to the first match; ST_UPDATE
// counts it and stores it if new and the table has room; ST_FLAG then registers the
// result. The scan reads one entry per cycle through one RAM read port and one
// 128-bit comparator. Asynchronous active-low reset clears the counters and the fill
// count; the table itself is never cleared. A waiting result does not block the input;
// a stalled result holds the following record in the flag stage, after its update.
`include "duplicate_record_filter_top_macros.svh"

module duplicate_record_filter_top
  import drf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  drf_in_if.sink     in_i,
  drf_out_if.source  out_o
);

  state_e            state_q, state_d;
  rec_t              rec_q, rec_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              pend_q, pend_d;
  logic              found_q, found_d;
  logic              stored_q, stored_d;
  logic [WordW-1:0]  dup_q, dup_d;
  logic [WordW-1:0]  acc_q, acc_d;

  logic              ovld_q, ovld_d;
  logic              onew_q, onew_d;
  logic              ostored_q, ostored_d;
  logic [WordW-1:0]  odup_q, odup_d;
  logic [WordW-1:0]  oacc_q, oacc_d;
  logic [UniqueW-1:0] ouniq_q, ouniq_d;
  logic              oprot_q, oprot_d;

  rec_t              rdata;
  logic              ram_we;
  logic              hit;
  logic              has_room;
  logic [WordW-1:0]  total;
  logic [ProdW-1:0]  dup_scaled;

  drf_ram #(
    .Width (RecW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (rec_q),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign hit        = pend_q && (rdata == rec_q);
  assign has_room   = (cnt_q < CntW'(TableDepth));
  assign total      = dup_q + acc_q;
  assign dup_scaled = ProdW'(dup_q) * ProdW'(PctScale);

  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = ovld_q;
  assign out_o.is_new         = onew_q;
  assign out_o.was_stored     = ostored_q;
  assign out_o.dup_count      = odup_q;
  assign out_o.acc_count      = oacc_q;
  assign out_o.unique_count   = ouniq_q;
  assign out_o.protected_flag = oprot_q;

  always_comb begin
    state_d   = state_q;
    rec_d     = rec_q;
    cnt_d     = cnt_q;
    issue_d   = issue_q;
    pend_d    = 1'b0;
    found_d   = found_q;
    stored_d  = stored_q;
    dup_d     = dup_q;
    acc_d     = acc_q;
    ram_we    = 1'b0;
    ovld_d    = ovld_q && !out_o.ready;
    onew_d    = onew_q;
    ostored_d = ostored_q;
    odup_d    = odup_q;
    oacc_d    = oacc_q;
    ouniq_d   = ouniq_q;
    oprot_d   = oprot_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rec_d   = {in_i.dest_node, in_i.source_node, in_i.stamp,
                     in_i.observed_word, in_i.observer_word};
          issue_d = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q < cnt_q) begin
          issue_d = issue_q + CntW'(1);
          pend_d  = 1'b1;
        end
        if (hit) begin
          found_d = 1'b1;
          state_d = ST_UPDATE;
        end else if (!pend_q && (issue_q == cnt_q)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        stored_d = 1'b0;
        if (found_q) begin
          dup_d = dup_q + WordW'(1);
        end else begin
          acc_d = acc_q + WordW'(1);
          if (has_room) begin
            ram_we   = 1'b1;
            cnt_d    = cnt_q + CntW'(1);
            stored_d = 1'b1;
          end
        end
        state_d = ST_FLAG;
      end
      ST_FLAG: begin
        if (!ovld_q || out_o.ready) begin
          ovld_d    = 1'b1;
          onew_d    = !found_q;
          ostored_d = stored_q;
          odup_d    = dup_q;
          oacc_d    = acc_q;
          ouniq_d   = UniqueW'(cnt_q);
          oprot_d   = (total == '0) || (dup_scaled < ProdW'(total));
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      dup_q   <= '0;
      acc_q   <= '0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dup_q   <= dup_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q     <= rec_d;
    issue_q   <= issue_d;
    found_q   <= found_d;
    stored_q  <= stored_d;
    onew_q    <= onew_d;
    ostored_q <= ostored_d;
    odup_q    <= odup_d;
    oacc_q    <= oacc_d;
    ouniq_q   <= ouniq_d;
    oprot_q   <= oprot_d;
  end

  `DRF_ASSERT_ALWAYS(a_fill_bounded, cnt_q <= CntW'(TableDepth))
  `DRF_ASSERT(a_accept_starts_scan, (in_i.valid && in_i.ready) |=> (state_q == ST_SCAN))
  `DRF_ASSERT(a_store_bumps_fill, ram_we |=> (cnt_q == $past(cnt_q) + CntW'(1)))
  `DRF_ASSERT(a_no_store_on_dup, ram_we |-> !found_q)

endmodule

>>> sv/drf_ram.sv
module drf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
